>>> sv/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
// No dependencies; imported by the cell, configuration and top-level modules.
package spq_pkg;

  // Operation codes carried in the mode field of an input transaction.
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Configuration register map.
  localparam int unsigned CFG_ADDR_WIDTH = 1;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_LARGEST_FIRST = 1'b0;
  localparam logic largest_first_RESET = 1'b1;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic push;          // insert the new entry at its ordered place
    logic pop;           // shift every entry one place toward the head
    logic largest_first; // ordering of the head
  } spq_ctl_t;

endpackage

>>> sv/spq_if.sv
// Valid/ready channel interfaces for the input and result transactions.
// Depends on nothing; widths are set by the instantiating level.
interface spq_in_if #(
  parameter int KEY_WIDTH     = 16,
  parameter int PAYLOAD_WIDTH = 32
);
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [KEY_WIDTH-1:0]     key;
  logic [PAYLOAD_WIDTH-1:0] payload;

  modport source (output valid, mode, key, payload, input ready);
  modport sink   (input valid, mode, key, payload, output ready);
endinterface

interface spq_out_if #(
  parameter int KEY_WIDTH     = 16,
  parameter int PAYLOAD_WIDTH = 32,
  parameter int COUNT_WIDTH   = 5
);
  logic                     valid;
  logic                     ready;
  logic [KEY_WIDTH-1:0]     head_key;
  logic [PAYLOAD_WIDTH-1:0] head_payload;
  logic                     is_empty;
  logic [COUNT_WIDTH-1:0]   entry_count;
  logic [1:0]               status;

  modport source (output valid, head_key, head_payload, is_empty, entry_count, status,
                  input ready);
  modport sink   (input valid, head_key, head_payload, is_empty, entry_count, status,
                  output ready);
endinterface

>>> sv/spq_cfg.sv
// APB-style configuration register block holding the head ordering bit.
// Depends on spq_pkg for the register map.
module spq_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [spq_pkg::CFG_ADDR_WIDTH-1:0]  cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready,
  output logic                                largest_first
);
  import spq_pkg::*;

  logic largest_first_r;
  logic largest_first_nxt;
  logic wr_hit;

  // A write completes in the access phase; pready is always high.
  assign cfg_pready = 1'b1;
  assign wr_hit     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr == REG_LARGEST_FIRST);

  always_comb begin
    largest_first_nxt = largest_first_r;
    if (wr_hit) begin
      largest_first_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      largest_first_r <= largest_first_RESET;
    end else begin
      largest_first_r <= largest_first_nxt;
    end
  end

  // Read decode.
  always_comb begin
    unique case (cfg_paddr)
      REG_LARGEST_FIRST: cfg_prdata = {31'd0, largest_first_r};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  assign largest_first = largest_first_r;
endmodule

>>> sv/spq_cell.sv
// One cell of the sorted chain: holds a key/payload entry, compares it with a
// pushed key and takes its own, its left or right neighbor's, or the new entry.
// Depends on spq_pkg for the command struct.
module spq_cell #(
  parameter int KEY_WIDTH     = 16,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                     clk,
  input  spq_pkg::spq_ctl_t        ctl,
  input  logic                     occupied,
  input  logic [KEY_WIDTH-1:0]     new_key,
  input  logic [PAYLOAD_WIDTH-1:0] new_payload,
  input  logic [KEY_WIDTH-1:0]     left_key,
  input  logic [PAYLOAD_WIDTH-1:0] left_payload,
  input  logic [KEY_WIDTH-1:0]     right_key,
  input  logic [PAYLOAD_WIDTH-1:0] right_payload,
  input  logic                     shift_in,
  output logic                     shift_out,
  output logic [KEY_WIDTH-1:0]     key_o,
  output logic [PAYLOAD_WIDTH-1:0] payload_o,
  output logic [KEY_WIDTH-1:0]     key_nxt_o,
  output logic [PAYLOAD_WIDTH-1:0] payload_nxt_o
);
  import spq_pkg::*;

  logic [KEY_WIDTH-1:0]     key_r;
  logic [KEY_WIDTH-1:0]     key_nxt;
  logic [PAYLOAD_WIDTH-1:0] payload_r;
  logic [PAYLOAD_WIDTH-1:0] payload_nxt;
  logic                     new_ahead;
  logic                     ins_here;

  // The new entry lands here when this cell is free or the new key ranks
  // strictly ahead of the held one; equal keys keep the older entry first.
  assign new_ahead = ctl.largest_first ? (new_key > key_r) : (new_key < key_r);
  assign ins_here  = !occupied || new_ahead;
  assign shift_out = shift_in || ins_here;

  always_comb begin
    key_nxt     = key_r;
    payload_nxt = payload_r;
    if (ctl.push) begin
      if (shift_in) begin
        key_nxt     = left_key;
        payload_nxt = left_payload;
      end else if (ins_here) begin
        key_nxt     = new_key;
        payload_nxt = new_payload;
      end
    end else if (ctl.pop) begin
      key_nxt     = right_key;
      payload_nxt = right_payload;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    payload_r <= payload_nxt;
  end

  assign key_o         = key_r;
  assign payload_o     = payload_r;
  assign key_nxt_o     = key_nxt;
  assign payload_nxt_o = payload_nxt;
endmodule

>>> sv/sorted_priority_queue_core.sv
// Sorted priority queue: usage notes.
// Input channel in_ch carries one operation per transaction: mode 0 pushes
// key/payload, mode 1 pops the head entry. Result channel out_ch returns one
// transaction per input: the head entry after the operation (zero when the
// queue is empty), the empty flag, the entry count and a status code
// (ok, push dropped because full, pop while empty).
// Entries live in a chain of DEPTH cells; every cell compares and shifts in
// the same cycle, so one operation is accepted per clock while results are
// taken. The result appears in the output register the cycle after acceptance.
// The output register parts the two sides: a new operation is accepted
// while the result is taken in the same cycle; if the receiver stalls, the
// held result stays and input is refused until it is taken.
// The cfg_ APB port writes largest_first (1: largest key at head); write it
// only while idle. Entries already held keep their order on a change.
// Synchronous active-low reset empties the queue, drops any pending result
// and sets largest_first to 1. Depends on spq_pkg, spq_if, spq_cfg, spq_cell.
module sorted_priority_queue_core #(
  parameter int DEPTH         = 16,
  parameter int KEY_WIDTH     = 16,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  spq_in_if.sink                             in_ch,
  spq_out_if.source                          out_ch,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [spq_pkg::CFG_ADDR_WIDTH-1:0] cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic                     largest_first;
  logic                     in_fire;
  logic                     q_full;
  logic                     q_empty;
  spq_ctl_t                 ctl;
  logic [1:0]               status_nxt;
  logic [CW-1:0]            count_r;
  logic [CW-1:0]            count_nxt;

  logic [KEY_WIDTH-1:0]     cell_key     [DEPTH];
  logic [PAYLOAD_WIDTH-1:0] cell_payload [DEPTH];
  logic [KEY_WIDTH-1:0]     cell_key_nxt [DEPTH];
  logic [PAYLOAD_WIDTH-1:0] cell_pay_nxt [DEPTH];
  logic [DEPTH:0]           shift_chain;

  logic                     out_valid_r;
  logic [KEY_WIDTH-1:0]     head_key_r;
  logic [PAYLOAD_WIDTH-1:0] head_payload_r;
  logic                     is_empty_r;
  logic [CW-1:0]            entry_count_r;
  logic [1:0]               status_r;

  // Configuration registers.
  spq_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .largest_first (largest_first)
  );

  // Accept while the output register is free or being emptied.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign q_full      = (count_r == CW'(DEPTH));
  assign q_empty     = (count_r == '0);

  // Command to the cell chain; dropped operations leave the cells unchanged.
  always_comb begin
    ctl.largest_first = largest_first;
    ctl.push          = in_fire && (in_ch.mode == MODE_PUSH) && !q_full;
    ctl.pop           = in_fire && (in_ch.mode == MODE_POP) && !q_empty;
  end

  // Occupancy and status.
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    if (in_ch.mode == MODE_PUSH) begin
      if (q_full) begin
        status_nxt = ST_FULL;
      end
    end else if (q_empty) begin
      status_nxt = ST_EMPTY;
    end
    if (ctl.push) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Chain of cells, head at index 0.
  assign shift_chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     occ;
    logic [KEY_WIDTH-1:0]     lk;
    logic [PAYLOAD_WIDTH-1:0] lp;
    logic [KEY_WIDTH-1:0]     rk;
    logic [PAYLOAD_WIDTH-1:0] rp;

    assign occ = (count_r > CW'(i));

    if (i == 0) begin : g_first
      assign lk = in_ch.key;
      assign lp = in_ch.payload;
    end else begin : g_left
      assign lk = cell_key[i-1];
      assign lp = cell_payload[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rk = cell_key[i];
      assign rp = cell_payload[i];
    end else begin : g_right
      assign rk = cell_key[i+1];
      assign rp = cell_payload[i+1];
    end

    spq_cell #(
      .KEY_WIDTH     (KEY_WIDTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_cell (
      .clk           (clk),
      .ctl           (ctl),
      .occupied      (occ),
      .new_key       (in_ch.key),
      .new_payload   (in_ch.payload),
      .left_key      (lk),
      .left_payload  (lp),
      .right_key     (rk),
      .right_payload (rp),
      .shift_in      (shift_chain[i]),
      .shift_out     (shift_chain[i+1]),
      .key_o         (cell_key[i]),
      .payload_o     (cell_payload[i]),
      .key_nxt_o     (cell_key_nxt[i]),
      .payload_nxt_o (cell_pay_nxt[i])
    );
  end

  // Result register: valid bit with reset, payload without.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      head_key_r     <= (count_nxt == '0) ? '0 : cell_key_nxt[0];
      head_payload_r <= (count_nxt == '0) ? '0 : cell_pay_nxt[0];
      is_empty_r     <= (count_nxt == '0);
      entry_count_r  <= count_nxt;
      status_r       <= status_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.head_key     = head_key_r;
  assign out_ch.head_payload = head_payload_r;
  assign out_ch.is_empty     = is_empty_r;
  assign out_ch.entry_count  = entry_count_r;
  assign out_ch.status       = status_r;
endmodule

>>> test/tb_sorted_priority_queue_core.sv
// Self-checking testbench for sorted_priority_queue_core: directed table then random phases.
// Depends on spq_pkg, spq_in_if/spq_out_if and the core; results are checked by a
// behavioral model of the sorted queue kept inside this file.
`timescale 1ns / 100ps

module tb_sorted_priority_queue_core;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH    = 16;
  localparam int KEY_W          = 16;
  localparam int PAY_W          = 32;
  localparam int COUNT_W        = 5;
  localparam int RESET_CYCLES   = 12;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 3;
  localparam int DIRECTED_ROWS  = 10;
  localparam int PHASES         = 7;

  // Head entry and bookkeeping returned by every transaction.
  typedef struct packed {
    logic [KEY_W-1:0]   head_key;
    logic [PAY_W-1:0]   head_payload;
    logic               is_empty;
    logic [COUNT_W-1:0] entry_count;
    logic [1:0]         status;
  } queue_view_t;

  // One directed row; reps > 1 repeats it with key and payload stepping by one.
  typedef struct packed {
    int          reps;
    logic        mode;
    logic [15:0] key;
    logic [31:0] payload;
    bit          typed;
    queue_view_t want;
  } stim_row_t;

  // One random phase: head ordering, share of pushes, length and idling style.
  typedef struct packed {
    bit lf;
    int push_pct;
    int count;
    bit calm;
    bit squeeze;
  } phase_t;

  logic clk;
  logic rst_n;
  logic                      cfg_psel;
  logic                      cfg_penable;
  logic                      cfg_pwrite;
  logic [CFG_ADDR_WIDTH-1:0] cfg_paddr;
  logic [31:0]               cfg_pwdata;
  logic [31:0]               cfg_prdata;
  logic                      cfg_pready;

  spq_in_if  #(.KEY_WIDTH(KEY_W), .PAYLOAD_WIDTH(PAY_W)) in_ch ();
  spq_out_if #(.KEY_WIDTH(KEY_W), .PAYLOAD_WIDTH(PAY_W), .COUNT_WIDTH(COUNT_W)) out_ch ();

  sorted_priority_queue_core #(
    .DEPTH(QUEUE_DEPTH),
    .KEY_WIDTH(KEY_W),
    .PAYLOAD_WIDTH(PAY_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Mirror of the queue contents and of the ordering register.
  logic [KEY_W-1:0] held_keys [QUEUE_DEPTH];
  logic [PAY_W-1:0] held_payloads [QUEUE_DEPTH];
  int               held;
  bit               head_largest;

  queue_view_t pending_views [$];
  int          mismatches;
  int          idle_cycles = 0;
  bit          offering;
  bit          sender_calm;
  bit          receiver_calm;
  bit          long_hold_due;

  // Side information travelling with the offered transaction.
  bit          item_typed;
  queue_view_t item_want;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{1, MODE_POP,  16'hFFFF, 32'hFFFF_FFFF, 1'b1, '{16'h0000, 32'h0, 1'b1, 5'd0, ST_EMPTY}},
    '{1, MODE_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
      '{16'hFFFF, 32'hFFFF_FFFF, 1'b0, 5'd1, ST_OK}},
    '{1, MODE_PUSH, 16'h0000, 32'h0000_0000, 1'b1,
      '{16'hFFFF, 32'hFFFF_FFFF, 1'b0, 5'd2, ST_OK}},
    // An equal key queues behind the older entry.
    '{1, MODE_PUSH, 16'hFFFF, 32'h1234_5678, 1'b1,
      '{16'hFFFF, 32'hFFFF_FFFF, 1'b0, 5'd3, ST_OK}},
    // Pops carry junk in key and payload, which must be ignored.
    '{1, MODE_POP,  16'h1234, 32'hDEAD_BEEF, 1'b1,
      '{16'hFFFF, 32'h1234_5678, 1'b0, 5'd2, ST_OK}},
    '{1, MODE_POP,  16'h0000, 32'hFFFF_FFFF, 1'b1, '{16'h0000, 32'h0, 1'b0, 5'd1, ST_OK}},
    '{1, MODE_POP,  16'hFFFF, 32'h0000_0000, 1'b1, '{16'h0000, 32'h0, 1'b1, 5'd0, ST_OK}},
    // Fill the queue to the brim.
    '{QUEUE_DEPTH, MODE_PUSH, 16'h8000, 32'hA000_0000, 1'b0, '0},
    '{1, MODE_PUSH, 16'hFFFF, 32'h5555_5555, 1'b1,
      '{16'h800F, 32'hA000_000F, 1'b0, 5'd16, ST_FULL}},
    '{1, MODE_POP,  16'h0000, 32'h0000_0000, 1'b0, '0}
  };

  phase_t phases [PHASES] = '{
    '{1'b0, 50, 300, 1'b0, 1'b0},
    '{1'b1, 85, 250, 1'b0, 1'b1},
    '{1'b0, 15, 250, 1'b0, 1'b0},
    '{1'b1, 60, 250, 1'b1, 1'b0},
    '{1'b0, 90, 250, 1'b0, 1'b0},
    '{1'b1, 25, 250, 1'b0, 1'b0},
    '{1'b0, 55, 250, 1'b0, 1'b0}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // True when key a belongs ahead of key b under the current ordering.
  function automatic bit ahead_of(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
    return head_largest ? (a > b) : (a < b);
  endfunction

  // Apply one operation to the mirror and return the view it leaves behind.
  function automatic queue_view_t apply_op(logic mode, logic [KEY_W-1:0] key,
                                           logic [PAY_W-1:0] payload);
    queue_view_t v;
    int pos;
    int i;
    v.status = ST_OK;
    if (mode == MODE_PUSH) begin
      if (held >= QUEUE_DEPTH) begin
        v.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held && !ahead_of(key, held_keys[pos])) pos++;
        for (i = held; i > pos; i--) begin
          held_keys[i]     = held_keys[i-1];
          held_payloads[i] = held_payloads[i-1];
        end
        held_keys[pos]     = key;
        held_payloads[pos] = payload;
        held++;
      end
    end else begin
      if (held == 0) begin
        v.status = ST_EMPTY;
      end else begin
        for (i = 0; i + 1 < held; i++) begin
          held_keys[i]     = held_keys[i+1];
          held_payloads[i] = held_payloads[i+1];
        end
        held--;
      end
    end
    if (held > 0) begin
      v.head_key     = held_keys[0];
      v.head_payload = held_payloads[0];
      v.is_empty     = 1'b0;
    end else begin
      v.head_key     = '0;
      v.head_payload = '0;
      v.is_empty     = 1'b1;
    end
    v.entry_count = held[COUNT_W-1:0];
    return v;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s at %0t: expected %h, got %h", what, $time, want, got);
  endtask

  // Mostly back to back, often a short pause, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one transaction and hold it until the core takes it.
  task automatic send_item(logic mode, logic [KEY_W-1:0] key, logic [PAY_W-1:0] payload,
                           bit typed, queue_view_t want);
    int gap;
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= mode;
    in_ch.key     <= key;
    in_ch.payload <= payload;
    item_typed    <= typed;
    item_want     <= want;
    offering = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    gap = sender_calm ? 0 : gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every pending result has come back.
  task automatic settle();
    if (offering) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
    end
    while (pending_views.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic cfg_access(bit wr, logic [CFG_ADDR_WIDTH-1:0] addr, logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_order(bit lf);
    logic [31:0] rd;
    cfg_access(1'b1, REG_LARGEST_FIRST, {31'b0, lf}, rd);
    head_largest = lf;
    cfg_access(1'b0, REG_LARGEST_FIRST, 32'h0, rd);
    if (rd[0] !== lf) note_mismatch("largest_first readback", {31'b0, lf}, rd);
  endtask

  // Keys lean on the extremes and on a narrow band so that ties are common.
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) return 16'h8000 + 16'($urandom_range(0, 3));
    return KEY_W'($urandom);
  endfunction

  function automatic logic [PAY_W-1:0] pick_payload();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (receiver_calm || $urandom_range(0, 2) != 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end
    end
  end

  // Track accepted operations and check every returned transaction.
  always @(posedge clk) begin : monitor
    queue_view_t want;
    queue_view_t seen;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        want = apply_op(in_ch.mode, in_ch.key, in_ch.payload);
        if (item_typed) want = item_want;
        pending_views.insert(pending_views.size(), want);
      end
      if (out_ch.valid && out_ch.ready) begin
        seen = '{out_ch.head_key, out_ch.head_payload, out_ch.is_empty,
                 out_ch.entry_count, out_ch.status};
        if (pending_views.size() == 0) begin
          note_mismatch("result with nothing pending", 32'h0, 32'h0);
        end else begin
          want = pending_views.pop_front();
          if (seen.head_key !== want.head_key)
            note_mismatch("head_key", 32'(want.head_key), 32'(seen.head_key));
          if (seen.head_payload !== want.head_payload)
            note_mismatch("head_payload", want.head_payload, seen.head_payload);
          if (seen.is_empty !== want.is_empty)
            note_mismatch("is_empty", 32'(want.is_empty), 32'(seen.is_empty));
          if (seen.entry_count !== want.entry_count)
            note_mismatch("entry_count", 32'(want.entry_count), 32'(seen.entry_count));
          if (seen.status !== want.status)
            note_mismatch("status", 32'(want.status), 32'(seen.status));
        end
      end
    end
  end

  // Watchdog: too long without any transaction on any port ends the run.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence: reset, directed table, then random phases under both orderings.
  initial begin
    stim_row_t   row;
    phase_t      ph;
    logic [31:0] rd;
    logic        mode;
    int          i;
    int          p;
    mismatches    = 0;
    held          = 0;
    head_largest  = largest_first_RESET;
    offering      = 1'b0;
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
    long_hold_due = 1'b0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.mode    <= MODE_PUSH;
    in_ch.key     <= '0;
    in_ch.payload <= '0;
    item_typed    <= 1'b0;
    item_want     <= '0;
    cfg_psel      <= 1'b0;
    cfg_penable   <= 1'b0;
    cfg_pwrite    <= 1'b0;
    cfg_paddr     <= '0;
    cfg_pwdata    <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // The ordering register must come out of reset with the largest key first.
    cfg_access(1'b0, REG_LARGEST_FIRST, 32'h0, rd);
    if (rd[0] !== largest_first_RESET)
      note_mismatch("largest_first after reset", {31'b0, largest_first_RESET}, rd);

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      row = directed_rows[i];
      for (p = 0; p < row.reps; p++)
        send_item(row.mode, row.key + 16'(p), row.payload + 32'(p), row.typed, row.want);
    end

    // Each phase changes the ordering while entries are still held.
    for (p = 0; p < PHASES; p++) begin
      ph = phases[p];
      settle();
      set_order(ph.lf);
      sender_calm   = ph.calm;
      receiver_calm = ph.calm;
      if (ph.squeeze) long_hold_due = 1'b1;
      for (i = 0; i < ph.count; i++) begin
        mode = ($urandom_range(0, 99) < ph.push_pct) ? MODE_PUSH : MODE_POP;
        send_item(mode, pick_key(), pick_payload(), 1'b0, '0);
      end
    end

    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
    settle();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
